// ===== rtl/tksa_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tksa_pkg: shared types, constants and functions for top-k score argsort
// Word formats, the token that travels down the insertion chain, the
// controller state encoding and the rank-order compare.
// ----------------------------------------------------------------------------
package tksa_pkg;

  // Capacity of the kept list and maximum run length.
  localparam int unsigned MAX_TOP     = 64;
  localparam int unsigned MAX_ENTRIES = 1024;

  // Field widths.
  localparam int unsigned INDEX_W = 10;
  localparam int unsigned SCORE_W = 32;
  localparam int unsigned COUNT_W = 7;

  // Derived widths.
  localparam int unsigned CELL_IDX_W = (MAX_TOP > 1) ? $clog2(MAX_TOP) : 1;
  localparam int unsigned CMP_W      = ((CELL_IDX_W > COUNT_W) ? CELL_IDX_W : COUNT_W) + 1;
  localparam int unsigned SEEN_W     = $clog2(MAX_ENTRIES + 1);

  // Configuration port.
  localparam int unsigned PADDR_W = 3;
  localparam int unsigned PDATA_W = 32;
  localparam logic [PADDR_W-3:0] REG_TOP_COUNT = '0;
  localparam logic [COUNT_W-1:0] TOP_COUNT_RESET = COUNT_W'(10);

  // Input word: one scored entry.
  typedef struct packed {
    logic [INDEX_W-1:0]        entry_index;
    logic signed [SCORE_W-1:0] score;
    logic                      last_entry;
  } in_word_t;

  // Output word: one ranked entry.
  typedef struct packed {
    logic [INDEX_W-1:0]        ranked_index;
    logic signed [SCORE_W-1:0] ranked_score;
    logic                      last_rank;
  } out_word_t;

  // One list slot.
  typedef struct packed {
    logic [INDEX_W-1:0]        idx;
    logic signed [SCORE_W-1:0] score;
  } slot_t;

  // What a token asks of the cells it passes.
  typedef enum logic [1:0] {
    TOK_NONE   = 2'd0,
    TOK_SEARCH = 2'd1,
    TOK_SHIFT  = 2'd2
  } tok_kind_e;

  // Token moving one cell per cycle down the chain.
  typedef struct packed {
    logic               valid;
    tok_kind_e          kind;
    logic               last;
    logic [COUNT_W-1:0] top_count;
    slot_t              slot;
  } token_t;

  // Controller states.
  typedef enum logic [1:0] {
    ST_RUN   = 2'd0,
    ST_DRAIN = 2'd1,
    ST_EMIT  = 2'd2
  } state_e;

  // Controller outputs to the datapath.
  typedef struct packed {
    logic in_ready;
    logic out_valid;
    logic emit_shift;
  } ctrl_t;

  // True when slot a ranks before slot b. Scores within one LSB tie, and
  // ties go to the lower index.
  function automatic logic ranks_before(slot_t a, slot_t b);
    logic signed [SCORE_W:0] diff;
    logic                    tie;
    diff = {a.score[SCORE_W-1], a.score} - {b.score[SCORE_W-1], b.score};
    tie  = (diff == (SCORE_W+1)'(0)) || (diff == (SCORE_W+1)'(1)) ||
           (diff == {(SCORE_W+1){1'b1}});
    if (tie) begin
      return a.idx < b.idx;
    end
    return a.score > b.score;
  endfunction

endpackage

// ===== rtl/tksa_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tksa_cell: one position of the ranked list
// Holds one slot, processes the token handed over by the previous cell and
// registers the token for the next one. During emission it takes the slot
// of the next cell so the list streams out of the head.
// ----------------------------------------------------------------------------
module tksa_cell (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic [tksa_pkg::CELL_IDX_W-1:0] cell_idx_i,
  input  tksa_pkg::token_t               tok_i,
  output tksa_pkg::token_t               tok_o,
  input  logic                           emit_shift_i,
  input  logic                           nbr_valid_i,
  input  tksa_pkg::slot_t                nbr_slot_i,
  output logic                           valid_o,
  output tksa_pkg::slot_t                slot_o
);

  logic             valid_q, valid_d;
  tksa_pkg::slot_t  slot_q, slot_d;
  tksa_pkg::token_t tok_q, tok_d;
  logic             active;
  logic             ahead;

  // The cell lies within the list capacity carried by the token.
  assign active = tksa_pkg::CMP_W'(cell_idx_i) < tksa_pkg::CMP_W'(tok_i.top_count);
  assign ahead  = tksa_pkg::ranks_before(tok_i.slot, slot_q);

  // Insertion, shift, truncation and emission.
  always_comb begin
    valid_d = valid_q;
    slot_d  = slot_q;
    tok_d   = tok_i;
    if (emit_shift_i) begin
      valid_d     = nbr_valid_i;
      slot_d      = nbr_slot_i;
      tok_d.valid = 1'b0;
    end else if (tok_i.valid) begin
      if (!active) begin
        valid_d = 1'b0;
      end else begin
        case (tok_i.kind)
          tksa_pkg::TOK_SEARCH: begin
            if (!valid_q) begin
              valid_d    = 1'b1;
              slot_d     = tok_i.slot;
              tok_d.kind = tksa_pkg::TOK_NONE;
            end else if (ahead) begin
              slot_d     = tok_i.slot;
              tok_d.kind = tksa_pkg::TOK_SHIFT;
              tok_d.slot = slot_q;
            end
          end
          tksa_pkg::TOK_SHIFT: begin
            slot_d = tok_i.slot;
            if (!valid_q) begin
              valid_d    = 1'b1;
              tok_d.kind = tksa_pkg::TOK_NONE;
            end else begin
              tok_d.slot = slot_q;
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      tok_q   <= '0;
    end else begin
      valid_q <= valid_d;
      tok_q   <= tok_d;
    end
  end

  // Slot payload.
  always_ff @(posedge clk_i) begin
    slot_q <= slot_d;
  end

  assign tok_o   = tok_q;
  assign valid_o = valid_q;
  assign slot_o  = slot_q;

endmodule

// ===== rtl/tksa_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tksa_ctrl: run control for top-k score argsort
// Counts entries of the run, forms the token for the head of the chain and
// sequences run, chain drain and emission.
// ----------------------------------------------------------------------------
module tksa_ctrl (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  input  tksa_pkg::in_word_t           in_word_i,
  input  logic [tksa_pkg::COUNT_W-1:0] top_count_i,
  input  logic                         out_ready_i,
  input  logic                         head_valid_i,
  input  tksa_pkg::token_t             tail_tok_i,
  output tksa_pkg::token_t             head_tok_o,
  output tksa_pkg::ctrl_t              ctrl_o
);

  tksa_pkg::state_e            state_q, state_d;
  logic [tksa_pkg::SEEN_W-1:0] seen_q, seen_d;
  logic                        accept;
  logic                        room;

  assign accept = in_valid_i && ctrl_o.in_ready;
  assign room   = seen_q < tksa_pkg::SEEN_W'(tksa_pkg::MAX_ENTRIES);

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      tksa_pkg::ST_RUN: begin
        if (accept && in_word_i.last_entry) begin
          state_d = tksa_pkg::ST_DRAIN;
        end
      end
      tksa_pkg::ST_DRAIN: begin
        if (tail_tok_i.valid && tail_tok_i.last) begin
          state_d = tksa_pkg::ST_EMIT;
        end
      end
      tksa_pkg::ST_EMIT: begin
        if (!head_valid_i) begin
          state_d = tksa_pkg::ST_RUN;
        end
      end
      default: begin
        state_d = tksa_pkg::ST_RUN;
      end
    endcase
  end

  // Outputs.
  always_comb begin
    ctrl_o = '0;
    case (state_q)
      tksa_pkg::ST_RUN: begin
        ctrl_o.in_ready = 1'b1;
      end
      tksa_pkg::ST_EMIT: begin
        ctrl_o.out_valid  = head_valid_i;
        ctrl_o.emit_shift = head_valid_i && out_ready_i;
      end
      default: begin
      end
    endcase
  end

  // Token entering the chain; entries past the run limit only truncate.
  always_comb begin
    head_tok_o.valid      = accept;
    head_tok_o.kind       = room ? tksa_pkg::TOK_SEARCH : tksa_pkg::TOK_NONE;
    head_tok_o.last       = in_word_i.last_entry;
    head_tok_o.top_count  = top_count_i;
    head_tok_o.slot.idx   = in_word_i.entry_index;
    head_tok_o.slot.score = in_word_i.score;
  end

  // Entries seen in the current run.
  always_comb begin
    seen_d = seen_q;
    if (accept) begin
      if (in_word_i.last_entry) begin
        seen_d = '0;
      end else if (room) begin
        seen_d = seen_q + tksa_pkg::SEEN_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= tksa_pkg::ST_RUN;
      seen_q  <= '0;
    end else begin
      state_q <= state_d;
      seen_q  <= seen_d;
    end
  end

endmodule

// ===== rtl/top_k_score_argsort_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// top_k_score_argsort_top: streaming top-k selection with ranked output
// Keeps the best entries of a run in a chain of insertion cells and, after
// the entry marked last, streams them out in rank order.
//
//   Channel  Direction  Handshake              Word
//   in       input      in_valid_i/in_ready_o  in_word_t (index, score, last)
//   out      output     out_valid_o/out_ready_i out_word_t (index, score, last)
//   cfg      input      APB psel/penable       top_count at byte address 0
//
// During a run one entry is taken every cycle; each entry walks the chain
// one cell per cycle, so entries overlap in the chain.
// After the last entry, input stalls while its token reaches the chain
// tail, then one rank per cycle leaves cell 0 (stalled by out_ready_i),
// then the controller returns to the run state once cell 0 is empty.
// Reset empties the list at once; no clearing pass is needed.
// ----------------------------------------------------------------------------
module top_k_score_argsort_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  tksa_pkg::in_word_t            in_word_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output tksa_pkg::out_word_t           out_word_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [tksa_pkg::PADDR_W-1:0]  paddr,
  input  logic [tksa_pkg::PDATA_W-1:0]  pwdata,
  output logic [tksa_pkg::PDATA_W-1:0]  prdata,
  output logic                          pready
);

  logic [tksa_pkg::COUNT_W-1:0] top_count_q;
  logic                         reg_sel;
  tksa_pkg::ctrl_t              ctrl;
  tksa_pkg::token_t             tok [0:tksa_pkg::MAX_TOP];
  logic                         cell_valid [0:tksa_pkg::MAX_TOP];
  tksa_pkg::slot_t              cell_slot [0:tksa_pkg::MAX_TOP];

  // Configuration register.
  assign pready  = 1'b1;
  assign reg_sel = paddr[tksa_pkg::PADDR_W-1:2] == tksa_pkg::REG_TOP_COUNT;
  assign prdata  = reg_sel ? tksa_pkg::PDATA_W'(top_count_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      top_count_q <= tksa_pkg::TOP_COUNT_RESET;
    end else if (psel && penable && pwrite && reg_sel) begin
      top_count_q <= pwdata[tksa_pkg::COUNT_W-1:0];
    end
  end

  // Run control.
  tksa_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_word_i    (in_word_i),
    .top_count_i  (top_count_q),
    .out_ready_i  (out_ready_i),
    .head_valid_i (cell_valid[0]),
    .tail_tok_i   (tok[tksa_pkg::MAX_TOP]),
    .head_tok_o   (tok[0]),
    .ctrl_o       (ctrl)
  );

  // Past the tail there is nothing to pull in during emission.
  assign cell_valid[tksa_pkg::MAX_TOP] = 1'b0;
  assign cell_slot[tksa_pkg::MAX_TOP]  = '0;

  // Insertion chain.
  for (genvar g = 0; g < tksa_pkg::MAX_TOP; g++) begin : g_cell
    tksa_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .cell_idx_i   (tksa_pkg::CELL_IDX_W'(g)),
      .tok_i        (tok[g]),
      .tok_o        (tok[g+1]),
      .emit_shift_i (ctrl.emit_shift),
      .nbr_valid_i  (cell_valid[g+1]),
      .nbr_slot_i   (cell_slot[g+1]),
      .valid_o      (cell_valid[g]),
      .slot_o       (cell_slot[g])
    );
  end

  // Handshake and ranked word from the head cell.
  assign in_ready_o              = ctrl.in_ready;
  assign out_valid_o             = ctrl.out_valid;
  assign out_word_o.ranked_index = cell_slot[0].idx;
  assign out_word_o.ranked_score = cell_slot[0].score;
  assign out_word_o.last_rank    = !cell_valid[1];

endmodule
